// ----- rtl/aagb_pkg.sv -----
`default_nettype none

package aagb_pkg;

	localparam int MAX_DIM = 1024;
	localparam int DIM_W = 11;
	localparam int SAT_DIM = (MAX_DIM > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_DIM;
	localparam int ROW_W = $clog2(MAX_DIM);
	localparam int ADDR_W = 20;
	localparam int POS_W = 16;
	localparam int MUL_A_W = (ROW_W + 1 > 8) ? ROW_W + 1 : 8;
	localparam int MUL_B_W = DIM_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
	localparam int BLEND_SHIFT = 8;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_NEWLINE = 2'd1,
		KIND_PIXEL   = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_TEXT_COLOUR    = 3'd0,
		REG_COVERAGE_DEPTH = 3'd1,
		REG_TARGET_WIDTH   = 3'd2,
		REG_TARGET_HEIGHT  = 3'd3,
		REG_LINE_HEIGHT    = 3'd4
	} cfg_reg_t;

	localparam logic [1:0] DEPTH_1BIT = 2'd0;
	localparam logic [1:0] DEPTH_2BIT = 2'd1;
	localparam logic [1:0] DEPTH_4BIT = 2'd2;
	localparam logic [1:0] DEPTH_8BIT = 2'd3;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [7:0]         coverage_byte;
		logic [2:0]         bit_offset;
		logic [15:0]        dest_pixel;
	} glyph_req_t;

	typedef struct packed {
		logic               write_enable;
		logic [19:0]        write_address;
		logic [15:0]        write_pixel;
		logic signed [15:0] pen_position;
	} glyph_rsp_t;

	typedef struct packed {
		logic       nonzero;
		logic       full;
		logic [7:0] alpha;
	} cov_t;

endpackage

`default_nettype wire

// ----- rtl/aagb_cov.sv -----
`default_nettype none

module aagb_cov import aagb_pkg::*; (
	input  wire logic [1:0] depth,
	input  wire logic [7:0] coverage_byte,
	input  wire logic [2:0] bit_offset,
	output cov_t            cov
);

	logic [7:0] value;
	logic [7:0] max_value;
	logic [2:0] shift;

	always_comb begin
		shift = 3'd6 - {bit_offset[2:1], 1'b0};
		value = '0;
		max_value = 8'hFF;
		cov.alpha = 8'hFF;
		unique case (depth)
			DEPTH_1BIT: begin
				value = {7'd0, coverage_byte[3'd7 - bit_offset]};
				max_value = 8'h01;
			end
			DEPTH_2BIT: begin
				value = (coverage_byte >> shift) & 8'h03;
				max_value = 8'h03;
				cov.alpha = {4{value[1:0]}};
			end
			DEPTH_4BIT: begin
				value = bit_offset[2] ? {4'd0, coverage_byte[3:0]} : {4'd0, coverage_byte[7:4]};
				max_value = 8'h0F;
				cov.alpha = {2{value[3:0]}};
			end
			default: begin
				value = coverage_byte;
				max_value = 8'hFF;
				cov.alpha = coverage_byte;
			end
		endcase
		cov.nonzero = (value != 8'd0);
		cov.full = (value == max_value);
	end

endmodule

`default_nettype wire

// ----- rtl/aagb_mul.sv -----
`default_nettype none

module aagb_mul import aagb_pkg::*; (
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] op_a,
	input  wire logic [MUL_B_W-1:0]        op_b,
	output logic signed [MUL_P_W-1:0]      prod_q
);

	logic signed [MUL_B_W:0] op_b_ext;

	assign op_b_ext = {1'b0, op_b};

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op_a * op_b_ext);
	end

endmodule

`default_nettype wire

// ----- rtl/aa_glyph_blit_rgb565_unit.sv -----
`default_nettype none

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   glyph_req_t
// out      output     out_valid / out_stall glyph_rsp_t
// cfg      input      cfg_we                cfg_index, cfg_data
//
// A start, newline or glyph end request runs S_EXEC then S_DONE, as does a pixel that is
// clipped or has zero coverage; a fully covered pixel adds S_ADDR, and a blended pixel
// adds S_ADDR, S_RED, S_GRN and S_BLU. The single shared multiplier forms the address
// product, then the red, green and blue blend products, one per cycle.
// Reset clears the pen, line and origin positions and loads the register defaults.
// in_stall is high from acceptance until the result enters the output register, which
// waits while an earlier result is held by out_stall.
module aa_glyph_blit_rgb565_unit import aagb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire glyph_req_t  in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output glyph_rsp_t       out_data,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ADDR,
		S_RED,
		S_GRN,
		S_BLU,
		S_DONE
	} state_t;

	state_t state_q;

	logic [15:0]      text_colour_q;
	logic [1:0]       coverage_depth_q;
	logic [DIM_W-1:0] target_width_q;
	logic [DIM_W-1:0] target_height_q;
	logic [7:0]       line_height_q;

	logic [15:0] pen_x_q;
	logic [15:0] line_y_q;
	logic [15:0] origin_x_q;

	glyph_req_t       req_q;
	glyph_rsp_t       res_q;
	glyph_rsp_t       out_q;
	logic             out_valid_q;
	logic [DIM_W-1:0] col_q;
	logic             full_q;
	logic [7:0]       alpha_q;

	cov_t                      cov;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [MUL_P_W-1:0] prod_q;

	logic [DIM_W-1:0]   width_eff;
	logic [DIM_W-1:0]   height_eff;
	logic [7:0]         line_step;
	logic signed [16:0] col;
	logic signed [16:0] row;
	logic               col_ok;
	logic               row_ok;
	logic               pix_write;
	logic [6:0]         diff_r;
	logic [6:0]         diff_g;
	logic [6:0]         diff_b;
	logic [5:0]         sum_r;
	logic [5:0]         sum_b;

	function automatic logic [5:0] blend_sum(input logic [5:0] d,
			input logic signed [MUL_P_W-1:0] p);
		logic signed [MUL_P_W-1:0] s;
		s = p >>> BLEND_SHIFT;
		return d + s[5:0];
	endfunction

	aagb_cov u_cov (
		.depth         (coverage_depth_q),
		.coverage_byte (req_q.coverage_byte),
		.bit_offset    (req_q.bit_offset),
		.cov           (cov)
	);

	aagb_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	assign width_eff = (target_width_q > DIM_W'(SAT_DIM)) ? DIM_W'(SAT_DIM) : target_width_q;
	assign height_eff = (target_height_q > DIM_W'(SAT_DIM)) ? DIM_W'(SAT_DIM) : target_height_q;
	assign line_step = (line_height_q == 8'd0) ? 8'd1 : line_height_q;

	assign col = {pen_x_q[15], pen_x_q} + {req_q.pos_x[15], req_q.pos_x};
	assign row = {line_y_q[15], line_y_q} + {req_q.pos_y[15], req_q.pos_y};
	assign col_ok = !col[16] && (col[15:0] < 16'(width_eff));
	assign row_ok = !row[16] && (row[15:0] < 16'(height_eff));
	assign pix_write = (req_q.kind == KIND_PIXEL) && cov.nonzero && col_ok && row_ok;

	assign diff_r = {2'b00, text_colour_q[15:11]} - {2'b00, req_q.dest_pixel[15:11]};
	assign diff_g = {1'b0, text_colour_q[10:5]} - {1'b0, req_q.dest_pixel[10:5]};
	assign diff_b = {2'b00, text_colour_q[4:0]} - {2'b00, req_q.dest_pixel[4:0]};

	assign sum_r = blend_sum({1'b0, req_q.dest_pixel[15:11]}, prod_q);
	assign sum_b = blend_sum({1'b0, req_q.dest_pixel[4:0]}, prod_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_EXEC: begin
				mul_a = MUL_A_W'({1'b0, row[ROW_W-1:0]});
				mul_b = width_eff;
			end
			S_ADDR: begin
				mul_a = {{(MUL_A_W-7){diff_r[6]}}, diff_r};
				mul_b = MUL_B_W'(alpha_q);
			end
			S_RED: begin
				mul_a = {{(MUL_A_W-7){diff_g[6]}}, diff_g};
				mul_b = MUL_B_W'(alpha_q);
			end
			S_GRN: begin
				mul_a = {{(MUL_A_W-7){diff_b[6]}}, diff_b};
				mul_b = MUL_B_W'(alpha_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			text_colour_q <= 16'hFFFF;
			coverage_depth_q <= DEPTH_4BIT;
			target_width_q <= DIM_W'(512);
			target_height_q <= DIM_W'(512);
			line_height_q <= 8'd16;
			pen_x_q <= '0;
			line_y_q <= '0;
			origin_x_q <= '0;
			out_valid_q <= 1'b0;
			req_q <= '0;
			res_q <= '0;
			out_q <= '0;
			col_q <= '0;
			full_q <= 1'b0;
			alpha_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TEXT_COLOUR:    text_colour_q <= cfg_data;
					REG_COVERAGE_DEPTH: coverage_depth_q <= cfg_data[1:0];
					REG_TARGET_WIDTH:   target_width_q <= cfg_data[DIM_W-1:0];
					REG_TARGET_HEIGHT:  target_height_q <= cfg_data[DIM_W-1:0];
					REG_LINE_HEIGHT:    line_height_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_q.write_enable <= pix_write;
					res_q.write_address <= '0;
					res_q.write_pixel <= '0;
					state_q <= pix_write ? S_ADDR : S_DONE;
					unique case (req_q.kind)
						KIND_START: begin
							pen_x_q <= req_q.pos_x;
							origin_x_q <= req_q.pos_x;
							line_y_q <= req_q.pos_y;
							res_q.pen_position <= req_q.pos_x;
						end
						KIND_NEWLINE: begin
							pen_x_q <= origin_x_q;
							line_y_q <= line_y_q + {8'd0, line_step};
							res_q.pen_position <= origin_x_q;
						end
						KIND_END: begin
							pen_x_q <= pen_x_q + req_q.pos_x;
							res_q.pen_position <= pen_x_q + req_q.pos_x;
						end
						default: begin
							res_q.pen_position <= pen_x_q;
							col_q <= col[DIM_W-1:0];
							full_q <= cov.full;
							alpha_q <= cov.alpha;
						end
					endcase
				end
				S_ADDR: begin
					res_q.write_address <= prod_q[ADDR_W-1:0] + ADDR_W'(col_q);
					if (full_q) begin
						res_q.write_pixel <= text_colour_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					res_q.write_pixel[15:11] <= sum_r[4:0];
					state_q <= S_GRN;
				end
				S_GRN: begin
					res_q.write_pixel[10:5] <= blend_sum(req_q.dest_pixel[10:5], prod_q);
					state_q <= S_BLU;
				end
				S_BLU: begin
					res_q.write_pixel[4:0] <= sum_b[4:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q <= res_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block not busy after accepting a request");

	a_no_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.write_enable) |->
			(out_data.write_address == '0 && out_data.write_pixel == '0))
		else $error("result without write carries address or pixel");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in progress");

endmodule

`default_nettype wire
